FILE: hdl/b64d_pkg.sv
// Base64 decoder package: shared types, constants and the character decode.
// No dependencies; the decoder modules and the testbench import this package.
`default_nettype none

package b64d_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nb;
    logic            fin;
  } entry_t;

  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    r = '0;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      r = {1'b1, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
    end else if (ch == CHAR_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (ch == CHAR_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/b64d_if.sv
// Base64 decoder channel interfaces: encoded text in, decoded bytes out.
// No dependencies.
`default_nettype none

interface b64d_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_final;

  modport source (output valid, output in_char, output in_final, input ready);
  modport sink (input valid, input in_char, input in_final, output ready);
endinterface

interface b64d_data_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_byte, output has_byte, output run_last,
                  output message_end, input ready);
  modport sink (input valid, input out_byte, input has_byte, input run_last,
                input message_end, output ready);
endinterface

`default_nettype wire

FILE: hdl/base64_decoder.sv
// Streaming Base64 decoder: one character per transaction in, one decoded
// byte (or bare end marker) per transaction out. A new character is taken
// every cycle while the entry queue (QUEUE_DEPTH entries) has room; the
// output register drains one byte per cycle unless stalled, so a full
// group of four characters, which gives three bytes, keeps pace at one
// character per cycle. Bytes pass from the queue into the output register;
// the back end byte serializer sets the output rate.
`default_nettype none

module base64_decoder #(
  parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  b64d_text_if.sink   text,
  b64d_data_if.source data
);
  import b64d_pkg::*;

  logic   push;
  logic   q_ready;
  logic   pop;
  logic   avail;
  entry_t wr_entry;
  entry_t head;

  b64d_front u_front (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .q_ready (q_ready),
    .push    (push),
    .entry   (wr_entry)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .ready    (q_ready),
    .pop      (pop),
    .avail    (avail),
    .head     (head)
  );

  b64d_back u_back (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .head  (head),
    .pop   (pop),
    .data  (data)
  );

endmodule

`default_nettype wire

FILE: hdl/b64d_front.sv
// Base64 decoder front end: accepts characters, tracks the sextet group and
// pushes a queue entry per byte-yielding or final character. Uses b64d_pkg.
`default_nettype none

module b64d_front (
  input  wire logic            clk,
  input  wire logic            rst,
  b64d_text_if.sink            text,
  input  wire logic            q_ready,
  output logic                 push,
  output b64d_pkg::entry_t     entry
);
  import b64d_pkg::*;

  logic [17:0] sext_buf;
  logic [1:0]  cnt;
  logic        stopped;

  logic [17:0] sext_buf_next;
  logic [1:0]  cnt_next;
  logic        stopped_next;
  logic [6:0]  sx;
  logic [23:0] word;
  logic        accept;

  assign text.ready = q_ready;
  assign accept     = text.valid && q_ready;
  assign sx         = sextet_of(text.in_char);
  assign word       = {sext_buf, sx[5:0]};

  always_comb begin
    sext_buf_next = sext_buf;
    cnt_next      = cnt;
    stopped_next  = stopped;
    entry.bytes   = '0;
    entry.nb      = 2'd0;
    entry.fin     = text.in_final;
    if (!stopped) begin
      if (!sx[6]) begin
        stopped_next = 1'b1;
        case (cnt)
          2'd2: begin
            entry.nb       = 2'd1;
            entry.bytes[0] = sext_buf[11:4];
          end
          2'd3: begin
            entry.nb       = 2'd2;
            entry.bytes[0] = sext_buf[17:10];
            entry.bytes[1] = sext_buf[9:2];
          end
          default: ;
        endcase
        sext_buf_next = '0;
        cnt_next      = 2'd0;
      end else if (cnt == 2'd3) begin
        entry.nb       = 2'd3;
        entry.bytes[0] = word[23:16];
        entry.bytes[1] = word[15:8];
        entry.bytes[2] = word[7:0];
        sext_buf_next  = '0;
        cnt_next       = 2'd0;
      end else begin
        sext_buf_next = {sext_buf[11:0], sx[5:0]};
        cnt_next      = cnt + 2'd1;
      end
    end
    // flush the partial group at the end of the message
    if (text.in_final && !stopped_next) begin
      case (cnt_next)
        2'd2: begin
          entry.nb       = 2'd1;
          entry.bytes[0] = sext_buf_next[11:4];
        end
        2'd3: begin
          entry.nb       = 2'd2;
          entry.bytes[0] = sext_buf_next[17:10];
          entry.bytes[1] = sext_buf_next[9:2];
        end
        default: ;
      endcase
    end
  end

  assign push = accept && (entry.nb != 2'd0 || text.in_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      sext_buf <= '0;
      cnt      <= 2'd0;
      stopped  <= 1'b0;
    end else if (accept) begin
      if (text.in_final) begin
        sext_buf <= '0;
        cnt      <= 2'd0;
        stopped  <= 1'b0;
      end else begin
        sext_buf <= sext_buf_next;
        cnt      <= cnt_next;
        stopped  <= stopped_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/b64d_queue.sv
// Base64 decoder entry queue between front end and back end.
// Uses b64d_pkg for the entry type.
`default_nettype none

module b64d_queue #(
  parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire b64d_pkg::entry_t wr_entry,
  output logic                  ready,
  input  wire logic             pop,
  output logic                  avail,
  output b64d_pkg::entry_t      head
);
  import b64d_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign ready = (count != CW'(DEPTH));
  assign avail = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> ready) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> avail) else $error("queue pop while empty");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

FILE: hdl/b64d_back.sv
// Base64 decoder back end: walks each queue entry byte by byte into the
// output register. Uses b64d_pkg.
`default_nettype none

module b64d_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             avail,
  input  wire b64d_pkg::entry_t head,
  output logic                  pop,
  b64d_data_if.source           data
);
  import b64d_pkg::*;

  logic [1:0] pos;
  logic       last;
  logic       load;

  assign last = (head.nb == 2'd0) || (pos == head.nb - 2'd1);
  assign load = !data.valid || data.ready;
  assign pop  = load && avail && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      data.valid <= 1'b0;
      pos        <= 2'd0;
    end else if (load) begin
      data.valid <= avail;
      if (avail) begin
        pos <= last ? 2'd0 : pos + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && avail) begin
      data.out_byte    <= (head.nb != 2'd0) ? head.bytes[pos] : 8'd0;
      data.has_byte    <= (head.nb != 2'd0);
      data.run_last    <= last;
      data.message_end <= last && head.fin;
    end
  end

`ifndef ASSERT_OFF
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (avail && head.nb != 2'd0) |-> pos < head.nb) else $error("byte index past entry");
  a_pos_rewind: assert property (@(posedge clk) disable iff (rst)
    pop |=> pos == 2'd0) else $error("byte index not rewound after pop");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (data.valid && !data.ready) |=> (data.valid && $stable(data.out_byte)))
    else $error("output transaction changed while stalled");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/base64_decoder_checker.sv
`timescale 1ns / 1ps
// Base64 decoder checker: decodes every accepted text transaction on its own
// and compares each data transaction with the oldest expected byte.
// Depends on b64d_pkg and the channel interfaces of b64d_if.sv.
module base64_decoder_checker (
  input  wire logic clk,
  input  wire logic rst,
  b64d_text_if      text,
  b64d_data_if      data,
  output int        errors,
  output int        pending
);
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       has_byte;
    logic       run_last;
    logic       message_end;
  } decoded_t;

  decoded_t    expected_bytes[$];
  decoded_t    char_bytes[$];
  logic [17:0] sextet_buf;
  logic [1:0]  sextet_cnt;
  logic        halted;
  int          mismatch_count;

  initial begin
    sextet_buf = '0;
    sextet_cnt = '0;
    halted = 1'b0;
    mismatch_count = 0;
  end

  function automatic logic [6:0] sextet_code(input logic [7:0] ch);
    logic [6:0] code;
    code = '0;
    if (ch >= "A" && ch <= "Z") begin
      code = {1'b1, 6'(ch - "A")};
    end else if (ch >= "a" && ch <= "z") begin
      code = {1'b1, 6'(ch - "a" + 8'd26)};
    end else if (ch >= "0" && ch <= "9") begin
      code = {1'b1, 6'(ch - "0" + 8'd52)};
    end else if (ch == CHAR_PLUS) begin
      code = {1'b1, 6'd62};
    end else if (ch == CHAR_SLASH) begin
      code = {1'b1, 6'd63};
    end
    return code;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    decoded_t d;
    d = '0;
    d.value = b;
    d.has_byte = 1'b1;
    char_bytes.push_back(d);
  endfunction

  function automatic void flush_group();
    if (sextet_cnt == 2'd2) begin
      add_byte(sextet_buf[11:4]);
    end else if (sextet_cnt == 2'd3) begin
      add_byte(sextet_buf[17:10]);
      add_byte(sextet_buf[9:2]);
    end
    sextet_buf = '0;
    sextet_cnt = '0;
  endfunction

  function automatic void decode_char(input logic [7:0] ch, input logic fin);
    logic [6:0]  code;
    logic [23:0] word;
    decoded_t    tail;
    code = sextet_code(ch);
    char_bytes.delete();
    if (!halted) begin
      if (!code[6]) begin
        flush_group();
        halted = 1'b1;
      end else if (sextet_cnt == 2'd3) begin
        word = {sextet_buf, code[5:0]};
        add_byte(word[23:16]);
        add_byte(word[15:8]);
        add_byte(word[7:0]);
        sextet_buf = '0;
        sextet_cnt = '0;
      end else begin
        sextet_buf = {sextet_buf[11:0], code[5:0]};
        sextet_cnt = sextet_cnt + 2'd1;
      end
    end
    if (fin) begin
      if (!halted) flush_group();
      if (char_bytes.size() == 0) char_bytes.push_back('0);
      tail = char_bytes.pop_back();
      tail.message_end = 1'b1;
      char_bytes.push_back(tail);
      sextet_buf = '0;
      sextet_cnt = '0;
      halted = 1'b0;
    end
    if (char_bytes.size() != 0) begin
      tail = char_bytes.pop_back();
      tail.run_last = 1'b1;
      char_bytes.push_back(tail);
    end
    foreach (char_bytes[i]) expected_bytes.push_back(char_bytes[i]);
  endfunction

  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (!rst) begin
      if (data.valid && data.ready) begin
        got = {data.out_byte, data.has_byte, data.run_last, data.message_end};
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected out_byte %02h has_byte %b run_last %b message_end %b",
                   $time, got.value, got.has_byte, got.run_last, got.message_end);
        end else begin
          want = expected_bytes.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display("%0t: expected out_byte %02h has_byte %b run_last %b message_end %b",
                     $time, want.value, want.has_byte, want.run_last, want.message_end);
            $display("%0t: actual   out_byte %02h has_byte %b run_last %b message_end %b",
                     $time, got.value, got.has_byte, got.run_last, got.message_end);
          end
        end
      end
      if (text.valid && text.ready) decode_char(text.in_char, text.in_final);
    end
    errors <= mismatch_count;
    pending <= expected_bytes.size();
  end

endmodule

FILE: tb/sv/base64_decoder_test.sv
`timescale 1ns / 1ps
// Base64 decoder testbench top: clock, reset, text stimulus and output stalls.
// Depends on b64d_pkg, b64d_if.sv, base64_decoder and base64_decoder_checker.
module base64_decoder_test;
  import b64d_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam int         CHAR_TARGET = 270;
  localparam logic [7:0] CHAR_PAD    = "=";

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   cycle_count;
  int   chars_sent = 0;
  int   steady_left = 0;
  int   stall_left = 0;
  int   open_left = 0;
  bit   drained_once = 1'b0;

  b64d_text_if text_ch();
  b64d_data_if data_ch();

  base64_decoder i_dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_ch),
    .data (data_ch)
  );

  base64_decoder_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .data    (data_ch),
    .errors  (mismatches),
    .pending (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    int r;
    r = 0;
    if (open_left > 0) begin
      open_left--;
      data_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      data_ch.ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        open_left = $urandom_range(40, 150);
        data_ch.ready <= 1'b1;
      end else if (r < 5) begin
        stall_left = $urandom_range(8, 40);
        data_ch.ready <= 1'b0;
      end else if (r < 30) begin
        stall_left = $urandom_range(0, 2);
        data_ch.ready <= 1'b0;
      end else begin
        data_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] char_of(input logic [5:0] s);
    if (s < 6'd26) return 8'("A") + 8'(s);
    if (s < 6'd52) return 8'("a") + 8'(s - 6'd26);
    if (s < 6'd62) return 8'("0") + 8'(s - 6'd52);
    if (s == 6'd62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  function automatic logic [7:0] stop_char();
    case ($urandom_range(0, 8))
      0: return CHAR_PAD;
      1: return "@";
      2: return "[";
      3: return 8'h60;
      4: return "{";
      5: return ":";
      6: return 8'($urandom_range(0, 42));
      7: return 8'($urandom_range(44, 46));
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  task automatic send_char(input logic [7:0] ch, input logic fin);
    int gap;
    int r;
    gap = 0;
    if (steady_left > 0) begin
      steady_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) steady_left = $urandom_range(20, 60);
      else if (r < 6) gap = $urandom_range(8, 30);
      else if (r < 30) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.in_char <= ch;
    text_ch.in_final <= fin;
    do @(posedge clk); while (!text_ch.ready);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_message();
    logic [7:0] chars[$];
    int         n;
    if ($urandom_range(0, 9) < 2) begin
      n = $urandom_range(1, 6);
      repeat (n) chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = 4 * $urandom_range(0, 3) + $urandom_range(0, 3);
      repeat (n) chars.push_back(char_of(6'($urandom())));
      case ($urandom_range(0, 3))
        0: ;
        1: repeat ((4 - n % 4) % 4) chars.push_back(CHAR_PAD);
        2: begin
          chars.push_back(stop_char());
          repeat ($urandom_range(0, 3)) chars.push_back(8'($urandom_range(0, 255)));
        end
        default: chars.push_back(stop_char());
      endcase
      if (chars.size() == 0) chars.push_back(stop_char());
    end
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // hold the text channel until every expected byte has come out
  task automatic drain_output();
    text_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("base64_decoder: mismatch");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    text_ch.valid <= 1'b0;
    text_ch.in_char <= '0;
    text_ch.in_final <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_text("//+z9AZa");
    send_text("TW=@");
    send_char("Q", 1'b0);
    send_char(8'hff, 1'b0);
    send_char(8'h00, 1'b1);
    send_text("TWF");
    send_text("0");
    send_char(8'h80, 1'b1);
    drain_output();

    while (chars_sent < CHAR_TARGET) begin
      send_message();
      if (!drained_once && chars_sent >= CHAR_TARGET / 2) begin
        drain_output();
        drained_once = 1'b1;
      end
    end

    drain_output();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("base64_decoder: match");
    end else begin
      $display("base64_decoder: mismatch");
    end
    $finish;
  end

endmodule
